[sv/assert_macros.svh]
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, cond, res, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (res)) \
        else $error(msg);
`endif

[sv/lltt_pkg.sv]
package lltt_pkg;
    localparam int TABLE_SIZE = 16;
    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam logic [1:0] REG_RHO_THR = 2'd0;
    localparam logic [1:0] REG_ALPHA_THR = 2'd1;
    localparam logic [1:0] REG_INIT_AGE = 2'd2;
    localparam logic OP_SEGMENT = 1'b0;
    localparam logic OP_END_FRAME = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic signed [31:0] rho;
        logic signed [31:0] alpha;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } in_item_t;

    typedef struct packed {
        logic [31:0] landmark_id;
        logic signed [31:0] out_rho;
        logic signed [31:0] out_alpha;
        logic signed [31:0] out_start_x;
        logic signed [31:0] out_start_y;
        logic signed [31:0] out_start_z;
        logic signed [31:0] out_end_x;
        logic signed [31:0] out_end_y;
        logic signed [31:0] out_end_z;
        logic        table_empty;
        logic [15:0] dropped_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] rho;
        logic [31:0] alpha;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
        logic [2:0]  age;
    } slot_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        slot_t             wdata;
        logic [SLOT_W-1:0] raddr;
    } mem_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_AGE, ST_EMIT, ST_EMPTY
    } state_t;
endpackage

[sv/lltt_slot_ram.sv]
module lltt_slot_ram (
    input  logic            aclk,
    input  lltt_pkg::mem_ctl_t ctl,
    output lltt_pkg::slot_t rdata
);
    import lltt_pkg::*;
    slot_t mem [TABLE_SIZE];
    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rdata <= mem[ctl.raddr];
    end
endmodule

[sv/line_landmark_track_table.sv]
// line landmark track table
// segment request: scans the slots in order, stopping at the first match or after the last slot,
// paced by the one-read-per-cycle slot memory scan
// end of frame: an ageing pass over every slot, then an emit pass that skips free slots, or one empty result
// synchronous active-low reset clears valid and mark bits, id and drop counters
module line_landmark_track_table (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lltt_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lltt_pkg::out_item_t  m_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [30:0]          cfg_data
);
    import lltt_pkg::*;
    `include "assert_macros.svh"

    state_t state_reg, state_next;
    logic [30:0] rho_thr_reg, alpha_thr_reg;
    logic [2:0] init_age_reg;
    logic [TABLE_SIZE-1:0] valid_reg, valid_next, mark_reg, mark_next;
    logic [31:0] next_id_reg, next_id_next;
    logic [15:0] drop_reg, drop_next;
    logic [SLOT_W:0] idx_reg, idx_next;
    in_item_t item_reg, item_next;
    logic m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;
    mem_ctl_t ctl;
    slot_t rdata;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;

    lltt_slot_ram u_ram (.aclk(aclk), .ctl(ctl), .rdata(rdata));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rho_thr_reg <= 31'd6554;
            alpha_thr_reg <= 31'd3277;
            init_age_reg <= 3'd5;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RHO_THR: rho_thr_reg <= cfg_data;
                REG_ALPHA_THR: alpha_thr_reg <= cfg_data;
                REG_INIT_AGE: init_age_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            mark_reg <= '0;
            next_id_reg <= '0;
            drop_reg <= '0;
            idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            mark_reg <= mark_next;
            next_id_reg <= next_id_next;
            drop_reg <= drop_next;
            idx_reg <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        m_data_reg <= m_data_next;
        rslot_reg <= rslot_next;
    end

    // match logic on the read slot and free-slot search over the valid bits
    logic signed [32:0] drho, dalpha;
    logic [32:0] adrho, adalpha;
    logic hit;
    logic signed [32:0] srho, salpha;
    logic [SLOT_W-1:0] free_slot;
    logic free_any;
    always_comb begin
        drho = 33'(signed'(item_reg.rho)) - 33'(signed'(rdata.rho));
        dalpha = 33'(signed'(item_reg.alpha)) - 33'(signed'(rdata.alpha));
        adrho = drho[32] ? 33'(-drho) : 33'(drho);
        adalpha = dalpha[32] ? 33'(-dalpha) : 33'(dalpha);
        hit = valid_reg[rslot_reg] && (adrho < {2'b0, rho_thr_reg})
              && (adalpha < {2'b0, alpha_thr_reg});
        srho = 33'(signed'(item_reg.rho)) + 33'(signed'(rdata.rho));
        salpha = 33'(signed'(item_reg.alpha)) + 33'(signed'(rdata.alpha));
        free_slot = '0;
        free_any = 1'b0;
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_slot = SLOT_W'(i);
                free_any = 1'b1;
            end
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_comb begin
        logic [SLOT_W-1:0] cur;
        logic [TABLE_SIZE-1:0] rest;
        cur = idx_reg[SLOT_W-1:0];
        rest = '0;
        state_next = state_reg;
        valid_next = valid_reg;
        mark_next = mark_reg;
        next_id_next = next_id_reg;
        drop_next = drop_reg;
        idx_next = idx_reg;
        item_next = item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next = m_data_reg;
        rslot_next = rslot_reg;
        ctl = '0;
        ctl.raddr = cur;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    idx_next = '0;
                    ctl.raddr = '0;
                    rslot_next = '0;
                    state_next = (s_data.opcode == OP_SEGMENT) ? ST_SCAN : ST_AGE;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    ctl.we = 1'b1;
                    ctl.waddr = rslot_reg;
                    ctl.wdata = rdata;
                    ctl.wdata.rho = srho[32:1];
                    ctl.wdata.alpha = salpha[32:1];
                    ctl.wdata.sx = item_reg.start_x;
                    ctl.wdata.sy = item_reg.start_y;
                    ctl.wdata.sz = item_reg.start_z;
                    ctl.wdata.ex = item_reg.end_x;
                    ctl.wdata.ey = item_reg.end_y;
                    ctl.wdata.ez = item_reg.end_z;
                    ctl.wdata.age = init_age_reg;
                    mark_next[rslot_reg] = 1'b1;
                    state_next = ST_IDLE;
                end else if (32'(rslot_reg) == TABLE_SIZE - 1) begin
                    if (free_any) begin
                        ctl.we = 1'b1;
                        ctl.waddr = free_slot;
                        ctl.wdata.id = next_id_reg;
                        ctl.wdata.rho = item_reg.rho;
                        ctl.wdata.alpha = item_reg.alpha;
                        ctl.wdata.sx = item_reg.start_x;
                        ctl.wdata.sy = item_reg.start_y;
                        ctl.wdata.sz = item_reg.start_z;
                        ctl.wdata.ex = item_reg.end_x;
                        ctl.wdata.ey = item_reg.end_y;
                        ctl.wdata.ez = item_reg.end_z;
                        ctl.wdata.age = init_age_reg;
                        valid_next[free_slot] = 1'b1;
                        mark_next[free_slot] = 1'b0;
                        next_id_next = next_id_reg + 32'd1;
                    end else if (drop_reg != 16'hFFFF) begin
                        drop_next = drop_reg + 16'd1;
                    end
                    state_next = ST_IDLE;
                end else begin
                    rslot_next = rslot_reg + SLOT_W'(1);
                    ctl.raddr = rslot_reg + SLOT_W'(1);
                end
            end
            ST_AGE: begin
                // rdata holds slot rslot_reg
                if (valid_reg[rslot_reg] && !mark_reg[rslot_reg]) begin
                    if (rdata.age <= 3'd1) begin
                        valid_next[rslot_reg] = 1'b0;
                    end else begin
                        ctl.we = 1'b1;
                        ctl.waddr = rslot_reg;
                        ctl.wdata = rdata;
                        ctl.wdata.age = rdata.age - 3'd1;
                    end
                end
                mark_next[rslot_reg] = 1'b0;
                if (32'(rslot_reg) == TABLE_SIZE - 1) begin
                    state_next = (valid_next == '0) ? ST_EMPTY : ST_EMIT;
                    rslot_next = '0;
                    ctl.raddr = '0;
                    idx_next = '0;
                end else begin
                    rslot_next = rslot_reg + SLOT_W'(1);
                    ctl.raddr = rslot_reg + SLOT_W'(1);
                end
            end
            ST_EMIT: begin
                // rdata is slot rslot_reg once the read settles
                if (!valid_reg[rslot_reg]) begin
                    rslot_next = rslot_reg + SLOT_W'(1);
                    ctl.raddr = rslot_reg + SLOT_W'(1);
                    idx_next = '0;
                end else if (idx_reg == '0) begin
                    idx_next = (SLOT_W + 1)'(1);
                    ctl.raddr = rslot_reg;
                end else if (out_free) begin
                    for (int i = 0; i < TABLE_SIZE; i++) begin
                        rest[i] = (i > 32'(rslot_reg)) && valid_reg[i];
                    end
                    m_valid_next = 1'b1;
                    m_data_next.landmark_id = rdata.id;
                    m_data_next.out_rho = rdata.rho;
                    m_data_next.out_alpha = rdata.alpha;
                    m_data_next.out_start_x = rdata.sx;
                    m_data_next.out_start_y = rdata.sy;
                    m_data_next.out_start_z = rdata.sz;
                    m_data_next.out_end_x = rdata.ex;
                    m_data_next.out_end_y = rdata.ey;
                    m_data_next.out_end_z = rdata.ez;
                    m_data_next.table_empty = 1'b0;
                    m_data_next.dropped_count = drop_reg;
                    m_data_next.last = (rest == '0);
                    idx_next = '0;
                    if (rest == '0) begin
                        drop_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        rslot_next = rslot_reg + SLOT_W'(1);
                        ctl.raddr = rslot_reg + SLOT_W'(1);
                    end
                end else begin
                    ctl.raddr = rslot_reg;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next = '0;
                    m_data_next.table_empty = 1'b1;
                    m_data_next.dropped_count = drop_reg;
                    m_data_next.last = 1'b1;
                    drop_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped")
    `ASSERT_NEXT(a_ready_idle, s_valid && s_ready, !s_ready, "request taken while busy")
    `ASSERT_CLK(a_empty_last, !(m_valid && m_data.table_empty && !m_data.last), "empty not last")
endmodule
